// ----- src/sapd_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table of the synchronous AM detector.
// Depends on nothing; the detector unit, sapd_cordic and sapd_mac import it.
`timescale 1ns / 1ps

package sapd_pkg;

    // CORDIC datapath: vectors in Q2.30 (or scaled detector input), angles in 32-bit turns.
    localparam int CORDIC_W     = 44;
    localparam int CORDIC_ZW    = 34;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_KW    = 5;

    // Width of the multiplier's first operand (sin/cos values and gains).
    localparam int MAC_AW = 33;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_DECAY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_DECAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELER_ON    = 3'd6;

    // Inverse CORDIC gain in Q2.30, and a quarter and a half turn.
    localparam logic signed [CORDIC_W-1:0]  INV_GAIN  = 44'sd652032874;
    localparam logic signed [CORDIC_ZW-1:0] Z_QUARTER = 34'sh0_4000_0000;
    localparam logic signed [CORDIC_ZW-1:0] Z_HALF    = 34'sh0_8000_0000;

    // Multiply-accumulate operations.
    typedef enum logic [1:0] {
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    typedef struct packed {
        logic    mul_en;
        logic    acc_en;
        t_mac_op op;
    } t_mac_ctl;

    typedef struct packed {
        logic start;
        logic rot_mode;
    } t_cordic_cmd;

    // Arctangent of 2^-k in 32-bit turns.
    function automatic logic signed [CORDIC_ZW-1:0] f_atan(input logic [CORDIC_KW-1:0] k);
        logic signed [CORDIC_ZW-1:0] v;
        case (k)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            5'd24:   v = 34'sd41;
            5'd25:   v = 34'sd20;
            5'd26:   v = 34'sd10;
            5'd27:   v = 34'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/sapd_if.sv -----
// Stream interfaces of the synchronous AM detector: sample requests in, result requests out.
// Depends on nothing.
`timescale 1ns / 1ps

interface sapd_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;

    modport source(output valid, output sample_i, output sample_q, input ready);
    modport sink(input valid, input sample_i, input sample_q, output ready);
endinterface

interface sapd_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] audio_out;
    logic signed [15:0]            freq_now;

    modport source(output valid, output audio_out, output freq_now, input ready);
    modport sink(input valid, input audio_out, input freq_now, output ready);
endinterface

// ----- src/sync_am_pll_detector_unit.sv -----
// Top level of the synchronous AM detector: configuration registers, sequencer and state.
// Depends on sapd_pkg, sapd_if, sapd_cordic and sapd_mac.
//
// Channel   Direction  Payload                        Handshake
// i_smp     in         sample_i, sample_q             valid / ready
// o_res     out        audio_out, freq_now            valid / ready
// i_cfg_*   in         i_cfg_idx, i_cfg_data          i_cfg_we, no wait
//
// Each sample uses the shared CORDIC's two 28-step passes (sin/cos, then atan2) and the
// shared multiplier, one product at a time. Leveling adds the DC and carrier products; a
// zero rotated vector skips the atan2 pass. i_smp.ready is high only while the sequencer
// is idle. A finished result waits in the output register while the next sample is taken.
// Reset is synchronous and active low and restores registers and loop state.
`timescale 1ns / 1ps

module sync_am_pll_detector_unit
    import sapd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sapd_in_if.sink               i_smp,
    sapd_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PB     = PHASE_BITS;
    localparam int MB_W   = (SB + 2 > 18) ? SB + 2 : 18;
    localparam int ACC_W  = MAC_AW + MB_W + 1;
    localparam int SATW   = ACC_W - 16;
    localparam int UP_SH  = 40 - SB;
    localparam int PH_UP  = (PB >= 16) ? PB - 16 : 0;
    localparam int PH_DN  = (PB >= 16) ? 0 : 16 - PB;
    localparam int PH_RND = (1 << PH_DN) >> 1;
    localparam int INC_W  = 18 + PH_UP + 1;

    localparam logic signed [ACC_W-1:0] BIAS_30 = ACC_W'(2 ** 29);
    localparam logic signed [ACC_W-1:0] BIAS_16 = ACC_W'(2 ** 15);
    localparam logic signed [SATW-1:0]  SAT_HI  = SATW'((2 ** (SB - 1)) - 1);
    localparam logic signed [SATW-1:0]  SAT_LO  = SATW'(-(2 ** (SB - 1)));

    // Multiplier steps.
    localparam logic [3:0] ST_C0_A = 4'd0;
    localparam logic [3:0] ST_C0_B = 4'd1;
    localparam logic [3:0] ST_C1_A = 4'd2;
    localparam logic [3:0] ST_C1_B = 4'd3;
    localparam logic [3:0] ST_DC_A = 4'd4;
    localparam logic [3:0] ST_DC_B = 4'd5;
    localparam logic [3:0] ST_CR_A = 4'd6;
    localparam logic [3:0] ST_CR_B = 4'd7;
    localparam logic [3:0] ST_INT  = 4'd8;
    localparam logic [3:0] ST_PROP = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_ROT_WAIT,
        S_MUL,
        S_VEC,
        S_VEC_WAIT,
        S_UPD,
        S_OUT
    } t_state;

    function automatic logic signed [SB-1:0] f_sat(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[SB-1:0];
    endfunction

    // Configuration registers.
    logic [15:0]        r_prop_gain;
    logic [15:0]        r_int_gain;
    logic signed [15:0] r_freq_min;
    logic signed [15:0] r_freq_max;
    logic [15:0]        r_dc_decay;
    logic [15:0]        r_carrier_decay;
    logic               r_leveler_on;

    // Sequencer, loop state and working registers.
    t_state                r_state;
    logic [3:0]            r_k;
    logic [1:0]            r_ph;
    logic signed [SB-1:0]  r_si;
    logic signed [SB-1:0]  r_sq;
    logic [PB-1:0]         r_phase;
    logic signed [15:0]    r_freq;
    logic signed [17:0]    r_prev;
    logic signed [SB-1:0]  r_dc;
    logic signed [SB-1:0]  r_carr;
    logic signed [SB:0]    r_c0;
    logic signed [SB:0]    r_c1;
    logic signed [SB+1:0]  r_raw;
    logic signed [17:0]    r_det;
    logic signed [17:0]    r_di;
    logic signed [17:0]    r_dp;
    logic signed [SB-1:0]  r_res_audio;
    logic                  r_out_valid;
    logic signed [SB-1:0]  r_out_audio;
    logic signed [15:0]    r_out_freq;

    // Shared unit connections.
    t_cordic_cmd                 w_cmd;
    logic signed [CORDIC_W-1:0]  w_cx;
    logic signed [CORDIC_W-1:0]  w_cy;
    logic signed [CORDIC_ZW-1:0] w_cz;
    logic signed [CORDIC_W-1:0]  w_ox;
    logic signed [CORDIC_W-1:0]  w_oy;
    logic signed [CORDIC_ZW-1:0] w_oz;
    logic                        w_cdone;
    t_mac_ctl                    w_mctl;
    logic signed [MAC_AW-1:0]    w_ma;
    logic signed [MB_W-1:0]      w_mb;
    logic signed [ACC_W-1:0]     w_bias;
    logic signed [ACC_W-1:0]     w_acc;

    // Derived values.
    logic signed [31:0]          w_ang;
    logic signed [CORDIC_ZW-1:0] w_zs;
    logic signed [CORDIC_W-1:0]  w_vx;
    logic signed [CORDIC_W-1:0]  w_vy;
    logic                        w_zero;
    logic signed [CORDIC_ZW-1:0] w_zr;
    logic signed [SB:0]          w_acc30;
    logic signed [SATW-1:0]      w_acc16;
    logic signed [18:0]          w_f;
    logic signed [15:0]          w_fc;
    logic signed [18:0]          w_prev;
    logic signed [INC_W-1:0]     w_inc_sum;
    logic signed [INC_W-1:0]     w_inc_sc;
    logic signed [PB+INC_W-1:0]  w_inc_ext;
    logic signed [SATW-1:0]      w_aud;

    sapd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_z     (w_cz),
        .o_x     (w_ox),
        .o_y     (w_oy),
        .o_z     (w_oz),
        .o_done  (w_cdone)
    );

    sapd_mac #(.B_W(MB_W)) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mctl),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .i_bias (w_bias),
        .o_acc  (w_acc)
    );

    // CORDIC start values: phase rotation folded into the right half plane, or the
    // detector vector scaled up and mirrored when it points left.
    always_comb begin
        w_ang  = {r_phase, {(32 - PB){1'b0}}};
        w_zs   = CORDIC_ZW'(w_ang);
        w_vx   = CORDIC_W'(r_c0) <<< UP_SH;
        w_vy   = CORDIC_W'(r_c1) <<< UP_SH;
        w_zero = (r_c0 == '0) && (r_c1 == '0);
        w_cmd.start    = (r_state == S_ROT) || ((r_state == S_VEC) && !w_zero);
        w_cmd.rot_mode = (r_state == S_ROT);
        if (r_state == S_VEC) begin
            if (r_c0[SB]) begin
                w_cx = -w_vx;
                w_cy = -w_vy;
                w_cz = r_c1[SB] ? -Z_HALF : Z_HALF;
            end else begin
                w_cx = w_vx;
                w_cy = w_vy;
                w_cz = '0;
            end
        end else begin
            w_cy = '0;
            if (w_zs > Z_QUARTER) begin
                w_cx = -INV_GAIN;
                w_cz = w_zs - Z_HALF;
            end else if (w_zs < -Z_QUARTER) begin
                w_cx = -INV_GAIN;
                w_cz = w_zs + Z_HALF;
            end else begin
                w_cx = INV_GAIN;
                w_cz = w_zs;
            end
        end
    end

    // Multiplier operands for each step.
    always_comb begin
        w_ma        = '0;
        w_mb        = '0;
        w_mctl.op   = MAC_LOAD;
        w_mctl.mul_en = (r_state == S_MUL) && (r_ph == 2'd0);
        w_mctl.acc_en = (r_state == S_MUL) && (r_ph == 2'd1);
        w_bias      = ((r_k == ST_C0_A) || (r_k == ST_C1_A)) ? BIAS_30 : BIAS_16;
        case (r_k)
            ST_C0_A: begin
                w_ma = w_ox[MAC_AW-1:0];
                w_mb = MB_W'(r_si);
            end
            ST_C0_B: begin
                w_ma = w_oy[MAC_AW-1:0];
                w_mb = MB_W'(r_sq);
                w_mctl.op = MAC_ADD;
            end
            ST_C1_A: begin
                w_ma = w_ox[MAC_AW-1:0];
                w_mb = MB_W'(r_sq);
            end
            ST_C1_B: begin
                w_ma = w_oy[MAC_AW-1:0];
                w_mb = MB_W'(r_si);
                w_mctl.op = MAC_SUB;
            end
            ST_DC_A: begin
                w_ma = $signed(MAC_AW'({1'b0, r_dc_decay}));
                w_mb = MB_W'(r_dc);
            end
            ST_DC_B: begin
                w_ma = $signed(MAC_AW'(17'h10000 - {1'b0, r_dc_decay}));
                w_mb = MB_W'(r_raw);
                w_mctl.op = MAC_ADD;
            end
            ST_CR_A: begin
                w_ma = $signed(MAC_AW'({1'b0, r_carrier_decay}));
                w_mb = MB_W'(r_carr);
            end
            ST_CR_B: begin
                w_ma = $signed(MAC_AW'(17'h10000 - {1'b0, r_carrier_decay}));
                w_mb = MB_W'(r_c0);
                w_mctl.op = MAC_ADD;
            end
            ST_INT: begin
                w_ma = $signed(MAC_AW'(r_int_gain));
                w_mb = MB_W'(r_det);
            end
            ST_PROP: begin
                w_ma = $signed(MAC_AW'(r_prop_gain));
                w_mb = MB_W'(r_det);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Rounded results, loop filter, phase step and audio, leveled when the leveler is on.
    always_comb begin
        w_acc30   = w_acc[30+SB:30];
        w_acc16   = w_acc[ACC_W-1:16];
        w_zr      = w_oz + CORDIC_ZW'(32768);
        w_f       = 19'(r_freq) + 19'(r_di);
        if (w_f < 19'(r_freq_min)) begin
            w_fc = r_freq_min;
        end else if (w_f > 19'(r_freq_max)) begin
            w_fc = r_freq_max;
        end else begin
            w_fc = w_f[15:0];
        end
        w_prev    = 19'(r_dp) + 19'(w_fc);
        w_inc_sum = (INC_W'(r_prev) <<< PH_UP) + INC_W'(PH_RND);
        w_inc_sc  = w_inc_sum >>> PH_DN;
        w_inc_ext = (PB + INC_W)'(w_inc_sc);
        if (r_leveler_on) begin
            w_aud = SATW'(r_raw) + SATW'(r_carr) - SATW'(r_dc);
        end else begin
            w_aud = SATW'(r_raw);
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= 16'd2000;
            r_int_gain      <= 16'd40;
            r_freq_min      <= -16'sd2731;
            r_freq_max      <= 16'sd2731;
            r_dc_decay      <= 16'd65470;
            r_carrier_decay <= 16'd65470;
            r_leveler_on    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                CFG_INT_GAIN:      r_int_gain      <= i_cfg_data;
                CFG_FREQ_MIN:      r_freq_min      <= $signed(i_cfg_data);
                CFG_FREQ_MAX:      r_freq_max      <= $signed(i_cfg_data);
                CFG_DC_DECAY:      r_dc_decay      <= i_cfg_data;
                CFG_CARRIER_DECAY: r_carrier_decay <= i_cfg_data;
                CFG_LEVELER_ON:    r_leveler_on    <= i_cfg_data[0];
                default:           r_leveler_on    <= r_leveler_on;
            endcase
        end
    end

    // Sequencer with loop state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= ST_C0_A;
            r_ph        <= 2'd0;
            r_phase     <= '0;
            r_freq      <= '0;
            r_prev      <= '0;
            r_dc        <= '0;
            r_carr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register reloads itself in S_OUT, so it is only cleared elsewhere.
            if (r_out_valid && o_res.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_smp.valid) begin
                        r_si    <= i_smp.sample_i;
                        r_sq    <= i_smp.sample_q;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_state <= S_ROT_WAIT;
                end
                S_ROT_WAIT: begin
                    if (w_cdone) begin
                        r_k     <= ST_C0_A;
                        r_ph    <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_ph != 2'd2) begin
                        r_ph <= r_ph + 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        r_k  <= r_k + 4'd1;
                        case (r_k)
                            ST_C0_B: r_c0 <= w_acc30;
                            ST_C1_B: begin
                                r_c1  <= w_acc30;
                                r_raw <= (SB + 2)'(r_c0) + (SB + 2)'(w_acc30);
                                if (!r_leveler_on) begin
                                    r_state <= S_VEC;
                                end
                            end
                            ST_DC_B: r_dc <= f_sat(w_acc16);
                            ST_CR_B: begin
                                r_carr  <= f_sat(w_acc16);
                                r_state <= S_VEC;
                            end
                            ST_INT:  r_di <= w_acc16[17:0];
                            ST_PROP: begin
                                r_dp    <= w_acc16[17:0];
                                r_state <= S_UPD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_VEC: begin
                    if (w_zero) begin
                        r_det   <= '0;
                        r_k     <= ST_INT;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_VEC_WAIT;
                    end
                end
                S_VEC_WAIT: begin
                    if (w_cdone) begin
                        r_det   <= w_zr[CORDIC_ZW-1:16];
                        r_k     <= ST_INT;
                        r_state <= S_MUL;
                    end
                end
                S_UPD: begin
                    r_freq      <= w_fc;
                    r_prev      <= w_prev[17:0];
                    r_phase     <= r_phase + w_inc_ext[PB-1:0];
                    r_res_audio <= f_sat(w_aud);
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_audio <= r_res_audio;
                        r_out_freq  <= r_freq;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_smp.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.audio_out = r_out_audio;
    assign o_res.freq_now  = r_out_freq;

endmodule

// ----- src/sapd_cordic.sv -----
// Shared CORDIC unit, one micro-rotation per cycle, in rotation or vectoring mode.
// Depends on sapd_pkg for widths, the step count and the arctangent table.
`timescale 1ns / 1ps

module sapd_cordic
    import sapd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cordic_cmd                 i_cmd,
    input  logic signed [CORDIC_W-1:0]  i_x,
    input  logic signed [CORDIC_W-1:0]  i_y,
    input  logic signed [CORDIC_ZW-1:0] i_z,
    output logic signed [CORDIC_W-1:0]  o_x,
    output logic signed [CORDIC_W-1:0]  o_y,
    output logic signed [CORDIC_ZW-1:0] o_z,
    output logic                        o_done
);

    logic                        r_busy;
    logic                        r_done;
    logic [CORDIC_KW-1:0]        r_k;
    logic                        r_rot;
    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic signed [CORDIC_ZW-1:0] r_z;

    logic signed [CORDIC_W-1:0]  w_xs;
    logic signed [CORDIC_W-1:0]  w_ys;
    logic signed [CORDIC_ZW-1:0] w_atan;
    logic                        w_pos;

    // Both modes share one update; only the direction decision differs.
    always_comb begin
        w_xs   = r_x >>> r_k;
        w_ys   = r_y >>> r_k;
        w_atan = f_atan(r_k);
        w_pos  = r_rot ? !r_z[CORDIC_ZW-1] : (r_y[CORDIC_W-1] || (r_y == '0));
    end

    // Step counter and completion strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_k == CORDIC_KW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // Vector and angle registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_rot <= i_cmd.rot_mode;
        end else if (r_busy) begin
            if (w_pos) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

// ----- src/sapd_mac.sv -----
// Shared multiply-accumulate unit: a registered product, then a registered accumulator.
// Depends on sapd_pkg for the operation codes and the first operand width.
`timescale 1ns / 1ps

module sapd_mac
    import sapd_pkg::*;
#(
    parameter int  B_W   = 18,
    localparam int ACC_W = MAC_AW + B_W + 1
) (
    input  logic                     i_clk,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [MAC_AW-1:0] i_a,
    input  logic signed [B_W-1:0]    i_b,
    input  logic signed [ACC_W-1:0]  i_bias,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [MAC_AW+B_W-1:0] r_prod;
    logic signed [ACC_W-1:0]      r_acc;

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // Accumulator: load with a rounding bias, add or subtract.
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            case (i_ctl.op)
                MAC_LOAD: r_acc <= ACC_W'(r_prod) + i_bias;
                MAC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
                MAC_SUB:  r_acc <= r_acc - ACC_W'(r_prod);
                default:  r_acc <= r_acc;
            endcase
        end
    end

    assign o_acc = r_acc;

endmodule
